>>> design/m3as_pkg.sv
package m3as_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int FRAC_BITS   = 8;
    localparam int LEVEL_BITS  = SAMPLE_BITS + FRAC_BITS;
    localparam int GAIN_BITS   = 9;
    localparam int GAIN_SHIFT  = 8;
    localparam int THR_BITS    = 10;
    localparam int CFG_BITS    = 10;
    localparam int PROD_BITS   = LEVEL_BITS + GAIN_BITS;
    localparam int RING_DEPTH  = 3;

    localparam logic [GAIN_BITS-1:0]  GAIN_ONE       = GAIN_BITS'(1 << GAIN_SHIFT);
    localparam logic [GAIN_BITS-1:0]  GAIN_SLOW_INIT = GAIN_BITS'(77);
    localparam logic [GAIN_BITS-1:0]  GAIN_FAST_INIT = GAIN_BITS'(230);
    localparam logic [THR_BITS-1:0]   THR_INIT       = THR_BITS'(10);
    localparam logic [PROD_BITS-1:0]  ROUND_DOWN     = PROD_BITS'((1 << GAIN_SHIFT) - 1);

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [LEVEL_BITS-1:0]  level_t;
    typedef logic [1:0]             slot_t;

    typedef enum logic [1:0] {
        REG_GAIN_SLOW      = 2'd0,
        REG_GAIN_FAST      = 2'd1,
        REG_JUMP_THRESHOLD = 2'd2
    } cfg_index_t;

    localparam slot_t SLOT_LAST = slot_t'(RING_DEPTH - 1);

    function automatic sample_t median3(input sample_t a, input sample_t b, input sample_t c);
        sample_t lo;
        sample_t hi;
        sample_t med;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c <= lo)
        begin
            med = lo;
        end
        else if (c >= hi)
        begin
            med = hi;
        end
        else
        begin
            med = c;
        end
        return med;
    endfunction

endpackage

>>> design/median3_adaptive_smoothing_unit.sv
// An accepted request passes through the input register and then the result register.
// Throughput: one request per cycle when not stalled; the median, gain select, multiply and
// level update all complete in the single stage between the input and result registers.
// Reset: ring, write slot and smoothed level clear to zero; gains return to 77 and 230,
// the jump threshold to 10; both valid flags drop.
module median3_adaptive_smoothing_unit
    import m3as_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [SAMPLE_BITS-1:0] sample_in,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [SAMPLE_BITS-1:0] filtered_out,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [CFG_BITS-1:0]    cfg_data
);

    logic                 in_valid_reg;
    sample_t              sample_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    sample_t              result_reg;
    sample_t              result_next;
    sample_t              ring_reg [RING_DEPTH];
    sample_t              ring_next [RING_DEPTH];
    slot_t                slot_reg;
    slot_t                slot_next;
    level_t               level_reg;
    level_t               level_next;
    logic [GAIN_BITS-1:0] gain_slow_reg;
    logic [GAIN_BITS-1:0] gain_fast_reg;
    logic [THR_BITS-1:0]  thr_reg;

    logic                 advance;
    logic                 in_take;
    slot_t                slot_eff;
    sample_t              med;
    level_t               target;
    logic                 neg;
    level_t               mag;
    level_t               thr_scaled;
    logic [GAIN_BITS-1:0] gain_sel;
    logic [GAIN_BITS-1:0] gain_sat;
    logic [PROD_BITS-1:0] prod_full;
    logic [PROD_BITS-1:0] prod_adj;
    level_t               step;

    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && out_valid_reg && out_stall;
    assign in_take   = in_valid && !in_stall;
    assign out_valid    = out_valid_reg;
    assign filtered_out = result_reg;

    always_comb
    begin
        slot_eff = (slot_reg > SLOT_LAST) ? slot_t'(0) : slot_reg;
        for (int i = 0; i < RING_DEPTH; i++)
        begin
            ring_next[i] = (slot_eff == slot_t'(i)) ? sample_reg : ring_reg[i];
        end
        slot_next  = (slot_eff >= SLOT_LAST) ? slot_t'(0) : slot_eff + slot_t'(1);

        med        = median3(ring_next[0], ring_next[1], ring_next[2]);
        target     = {med, {FRAC_BITS{1'b0}}};
        neg        = target < level_reg;
        mag        = neg ? (level_reg - target) : (target - level_reg);
        thr_scaled = {thr_reg, {FRAC_BITS{1'b0}}};

        gain_sel   = (mag > thr_scaled) ? gain_fast_reg : gain_slow_reg;
        gain_sat   = (gain_sel > GAIN_ONE) ? GAIN_ONE : gain_sel;

        prod_full  = PROD_BITS'(mag) * PROD_BITS'(gain_sat);
        prod_adj   = neg ? (prod_full + ROUND_DOWN) : prod_full;
        step       = prod_adj[GAIN_SHIFT +: LEVEL_BITS];
        level_next = neg ? (level_reg - step) : (level_reg + step);

        result_next    = level_next[LEVEL_BITS-1:FRAC_BITS];
        out_valid_next = advance || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            slot_reg      <= '0;
            level_reg     <= '0;
            for (int i = 0; i < RING_DEPTH; i++)
            begin
                ring_reg[i] <= '0;
            end
            gain_slow_reg <= GAIN_SLOW_INIT;
            gain_fast_reg <= GAIN_FAST_INIT;
            thr_reg       <= THR_INIT;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                slot_reg  <= slot_next;
                level_reg <= level_next;
                for (int i = 0; i < RING_DEPTH; i++)
                begin
                    ring_reg[i] <= ring_next[i];
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_GAIN_SLOW:      gain_slow_reg <= cfg_data[GAIN_BITS-1:0];
                    REG_GAIN_FAST:      gain_fast_reg <= cfg_data[GAIN_BITS-1:0];
                    REG_JUMP_THRESHOLD: thr_reg       <= cfg_data[THR_BITS-1:0];
                    default:            ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            sample_reg <= sample_in;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

endmodule
